>>> src/itoa_pkg.sv
package itoa_pkg;

	localparam int VALUE_BITS = 32;
	localparam int DEC_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
	localparam int CNT_BITS = $clog2(DEC_DIGITS + 1);
	localparam int RECIP_SHIFT = VALUE_BITS + 3;
	localparam int PROD_BITS = 2 * VALUE_BITS;

	localparam logic [VALUE_BITS+3:0] RECIP_FULL =
		({1'b1, {(VALUE_BITS + 3){1'b0}}} / (VALUE_BITS + 4)'(10)) + (VALUE_BITS + 4)'(1);
	localparam logic [VALUE_BITS-1:0] RECIP = RECIP_FULL[VALUE_BITS-1:0];

	localparam logic KIND_DEC = 1'b0;
	localparam logic KIND_HEX = 1'b1;

	localparam logic [6:0] CHAR_ZERO  = 7'h30;
	localparam logic [6:0] CHAR_A_LC  = 7'h61;
	localparam logic [6:0] CHAR_MINUS = 7'h2d;
	localparam logic [3:0] DIGIT_TEN  = 4'd10;

	typedef struct packed {
		logic                  hex;
		logic                  neg;
		logic [VALUE_BITS-1:0] mag;
	} item_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_CONV,
		BK_EMIT
	} back_state_t;

	function automatic logic [6:0] digit_char(input logic [3:0] d);
		logic [6:0] c;
		if (d < DIGIT_TEN) begin
			c = CHAR_ZERO + {3'b000, d};
		end else begin
			c = CHAR_A_LC + {3'b000, d} - {3'b000, DIGIT_TEN};
		end
		return c;
	endfunction

endpackage

>>> src/itoa_in_if.sv
interface itoa_in_if;
	logic                            valid;
	logic                            ready;
	logic                            kind;
	logic [itoa_pkg::VALUE_BITS-1:0] value;

	modport source (output valid, output kind, output value, input ready);
	modport sink (input valid, input kind, input value, output ready);
endinterface

>>> src/itoa_out_if.sv
interface itoa_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] character;
	logic       last;

	modport source (output valid, output character, output last, input ready);
	modport sink (input valid, input character, input last, output ready);
endinterface

>>> src/integer_to_ascii_dec_hex_unit.sv
// The back end sets the throughput: it takes a number from the queue only when idle
// and finishes it before taking the next, first peeling off the digits (divide by ten,
// or a four-bit shift for hex), then sending the minus sign, if any, and the digits
// one character at a time as the output accepts them.
// Reset: arst_n clears the queue, the state machine and the output valid at once.
module integer_to_ascii_dec_hex_unit (
	input logic        clk,
	input logic        arst_n,
	itoa_in_if.sink    din,
	itoa_out_if.source dout
);
	import itoa_pkg::*;

	logic  fq_valid;
	logic  fq_ready;
	item_t fq_item;
	logic  qb_valid;
	logic  qb_ready;
	item_t qb_item;

	itoa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.din        (din),
		.item_valid (fq_valid),
		.item_ready (fq_ready),
		.item       (fq_item)
	);

	itoa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_valid),
		.wr_ready (fq_ready),
		.wr_item  (fq_item),
		.rd_valid (qb_valid),
		.rd_ready (qb_ready),
		.rd_item  (qb_item)
	);

	itoa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (qb_valid),
		.item_ready (qb_ready),
		.item       (qb_item),
		.dout       (dout)
	);
endmodule

>>> src/itoa_front.sv
module itoa_front (
	input  logic            clk,
	input  logic            arst_n,
	itoa_in_if.sink         din,
	output logic            item_valid,
	input  logic            item_ready,
	output itoa_pkg::item_t item
);
	import itoa_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	item_t item_d;
	logic  accept;

	assign din.ready = !valid_s1 || item_ready;
	assign accept = din.valid && din.ready;

	always_comb begin
		item_d.hex = (din.kind == KIND_HEX);
		item_d.neg = (din.kind == KIND_DEC) && din.value[VALUE_BITS-1];
		item_d.mag = item_d.neg ? (~din.value + VALUE_BITS'(1)) : din.value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (item_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

	assign item_valid = valid_s1;
	assign item = item_s1;
endmodule

>>> src/itoa_queue.sv
module itoa_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_valid,
	output logic            wr_ready,
	input  itoa_pkg::item_t wr_item,
	output logic            rd_valid,
	input  logic            rd_ready,
	output itoa_pkg::item_t rd_item
);
	import itoa_pkg::*;

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;
	assign rd_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end
endmodule

>>> src/itoa_back.sv
module itoa_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  itoa_pkg::item_t item,
	itoa_out_if.source      dout
);
	import itoa_pkg::*;

	back_state_t           state_q;
	back_state_t           state_d;
	logic [VALUE_BITS-1:0] mag_q;
	logic                  hex_q;
	logic                  sign_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [3:0]            stack_q [DEC_DIGITS];
	logic                  out_valid_q;
	logic [6:0]            char_q;
	logic                  last_q;

	logic [PROD_BITS-1:0]  prod;
	logic [VALUE_BITS-1:0] quot;
	logic [3:0]            rem;
	logic [3:0]            digit;
	logic [VALUE_BITS-1:0] mag_next;
	logic                  out_load;
	logic                  do_pop;
	logic                  do_conv;
	logic                  do_emit;
	logic                  final_char;

	assign prod = PROD_BITS'(mag_q) * PROD_BITS'(RECIP);
	assign quot = VALUE_BITS'(prod >> RECIP_SHIFT);
	assign rem = mag_q[3:0] - ({quot[2:0], 1'b0} + {quot[0], 3'b000});
	assign digit = hex_q ? mag_q[3:0] : rem;
	assign mag_next = hex_q ? (mag_q >> 4) : quot;
	assign out_load = !out_valid_q || dout.ready;
	assign final_char = !sign_q && (cnt_q == CNT_BITS'(1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (item_valid) begin
					state_d = BK_CONV;
				end
			end
			BK_CONV: begin
				if (mag_next == '0) begin
					state_d = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (out_load && final_char) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		do_pop = 1'b0;
		do_conv = 1'b0;
		do_emit = 1'b0;
		case (state_q)
			BK_IDLE: do_pop = item_valid;
			BK_CONV: do_conv = 1'b1;
			BK_EMIT: do_emit = out_load;
			default: begin
				do_pop = 1'b0;
				do_conv = 1'b0;
				do_emit = 1'b0;
			end
		endcase
	end

	assign item_ready = do_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			cnt_q <= '0;
			sign_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_pop) begin
				cnt_q <= '0;
				sign_q <= item.neg;
			end else if (do_conv) begin
				cnt_q <= cnt_q + CNT_BITS'(1);
			end else if (do_emit) begin
				if (sign_q) begin
					sign_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - CNT_BITS'(1);
				end
			end
			if (do_emit) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop) begin
			mag_q <= item.mag;
			hex_q <= item.hex;
		end else if (do_conv) begin
			mag_q <= mag_next;
		end
		if (do_conv) begin
			stack_q[0] <= digit;
			for (int i = 1; i < DEC_DIGITS; i++) begin
				stack_q[i] <= stack_q[i-1];
			end
		end else if (do_emit && !sign_q) begin
			for (int i = 0; i < DEC_DIGITS - 1; i++) begin
				stack_q[i] <= stack_q[i+1];
			end
		end
		if (do_emit) begin
			char_q <= sign_q ? CHAR_MINUS : digit_char(stack_q[0]);
			last_q <= final_char;
		end
	end

	assign dout.valid = out_valid_q;
	assign dout.character = char_q;
	assign dout.last = last_q;
endmodule
